@@ rtl/tcgi_pkg.sv @@
// Shared constants and types for the greedy insertion block that builds cycles A and B.
`default_nettype none
package tcgi_pkg;
    localparam int MAX_NODES  = 64;
    localparam int MIN_NODES  = 4;
    localparam int NODE_W     = 6;
    localparam int DIST_W     = 16;
    localparam int DADDR_W    = 2 * NODE_W;
    localparam int POS_W      = 5;
    localparam int LEN_W      = POS_W + 1;
    localparam int CNT_W      = NODE_W + 1;
    localparam int SUM_W      = DIST_W + 1;
    localparam int VAL_W      = DIST_W + 2;
    localparam int LADDR_W    = POS_W + 1;

    // register word index and opcode values
    localparam logic       REG_NODE_COUNT = 1'b0;
    localparam logic [0:0] OP_WRITE       = 1'b0;
    localparam logic [0:0] OP_RUN         = 1'b1;
    localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(MAX_NODES);

    // request to the shared add/compare unit
    typedef struct packed {
        logic [SUM_W-1:0]        a;
        logic [DIST_W-1:0]       b;
        logic [DIST_W-1:0]       c;
        logic signed [VAL_W-1:0] best;
        logic                    have;
        logic                    far;
    } t_cmp_req;
endpackage
`default_nettype wire

@@ rtl/tcgi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tcgi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/tcgi_cmp.sv @@
// Shared add/subtract and compare unit: val = a + b - c, take if better than best.
`default_nettype none
module tcgi_cmp
    import tcgi_pkg::*;
(
    input  wire t_cmp_req                i_req,
    output logic signed [VAL_W-1:0]      o_val,
    output logic                         o_take
);
    always_comb begin
        o_val  = $signed({1'b0, i_req.a}) + $signed({2'b00, i_req.b})
                 - $signed({2'b00, i_req.c});
        // first candidate always wins; later ones only when strictly better
        o_take = !i_req.have || (i_req.far ? (o_val > i_req.best) : (o_val < i_req.best));
    end
endmodule
`default_nettype wire

@@ rtl/two_cycle_greedy_insertion.sv @@
// Top level: distance store, cycle lists and the construction sequencer.
// Write items (opcode 0) are taken one per cycle and go straight into the
// 64x64 distance store. A run item (opcode 1) builds cycles A and B by greedy
// insertion, then emits cycle A followed by cycle B, one transfer per node,
// with last set on the final one. During a run the input is stalled. Each
// candidate in a scan needs one distance read, two for pair scans; a grow
// step tests all n node indices for each adjacent pair of entries in the
// cycle, so run time is bound by the single read port of the distance
// store. Each result is held while the output is stalled. node_count is
// read at run start and saturated into [4, 64].
`default_nettype none
module two_cycle_greedy_insertion
    import tcgi_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // item input
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [0:0]        i_opcode,
    input  wire logic [NODE_W-1:0] i_row_index,
    input  wire logic [NODE_W-1:0] i_col_index,
    input  wire logic [DIST_W-1:0] i_distance_value,
    input  wire logic [NODE_W-1:0] i_start_node,
    // result output
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [0:0]             o_cycle_id,
    output logic [POS_W-1:0]       o_position,
    output logic [NODE_W-1:0]      o_node,
    output logic [0:0]             o_last,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_START    = 5'd1;
    localparam logic [4:0] S_FAR_DONE = 5'd2;
    localparam logic [4:0] S_A1_DONE  = 5'd3;
    localparam logic [4:0] S_B1_DONE  = 5'd4;
    localparam logic [4:0] S_SC_TEST  = 5'd5;
    localparam logic [4:0] S_SC_RD1   = 5'd6;
    localparam logic [4:0] S_SC_RD2   = 5'd7;
    localparam logic [4:0] S_G_INIT   = 5'd8;
    localparam logic [4:0] S_G_RD0    = 5'd9;
    localparam logic [4:0] S_P_ISSUE  = 5'd10;
    localparam logic [4:0] S_P_GET    = 5'd11;
    localparam logic [4:0] S_P_DFS    = 5'd12;
    localparam logic [4:0] S_P_COST   = 5'd13;
    localparam logic [4:0] S_I_RD     = 5'd14;
    localparam logic [4:0] S_I_WR     = 5'd15;
    localparam logic [4:0] S_NEXT     = 5'd16;
    localparam logic [4:0] S_O_ISSUE  = 5'd17;
    localparam logic [4:0] S_O_LOAD   = 5'd18;
    localparam logic [4:0] S_O_WAIT   = 5'd19;

    // where a finished scan returns to
    localparam logic [1:0] RET_FAR  = 2'd0;
    localparam logic [1:0] RET_A1   = 2'd1;
    localparam logic [1:0] RET_B1   = 2'd2;
    localparam logic [1:0] RET_PAIR = 2'd3;

    logic [4:0]              r_state;
    logic [1:0]              r_ret;
    logic [CNT_W-1:0]        r_cfg_n;
    logic [CNT_W-1:0]        r_n;
    logic [LEN_W-1:0]        r_full_a, r_full_b;
    logic [LEN_W-1:0]        r_len_a, r_len_b;
    logic [MAX_NODES-1:0]    r_used;
    logic [NODE_W-1:0]       r_start, r_far;
    logic                    r_cyc;
    // scan unit state
    logic [NODE_W-1:0]       r_p, r_q;
    logic [CNT_W-1:0]        r_x;
    logic                    r_pair, r_far_mode, r_have;
    logic [DIST_W-1:0]       r_d1;
    logic [NODE_W-1:0]       r_best_x;
    logic signed [VAL_W-1:0] r_best_val;
    // grow step state
    logic [POS_W-1:0]        r_j, r_gj, r_k;
    logic [NODE_W-1:0]       r_prev, r_gx;
    logic signed [VAL_W-1:0] r_gcost;
    logic                    r_ghave;
    // output walk
    logic                    r_oc;
    logic [POS_W-1:0]        r_opos;
    logic                    r_o_valid;
    logic                    r_o_cyc, r_o_last;
    logic [POS_W-1:0]        r_o_pos;
    logic [NODE_W-1:0]       r_o_node;

    logic                    in_xfer, d_we;
    logic [DADDR_W-1:0]      d_raddr;
    logic [DIST_W-1:0]       d_rdata;
    logic                    l_we;
    logic [LADDR_W-1:0]      l_waddr, l_raddr;
    logic [NODE_W-1:0]       l_wdata, l_rdata;
    t_cmp_req                cmp_req;
    logic signed [VAL_W-1:0] cmp_val;
    logic                    cmp_take;
    logic [LEN_W-1:0]        cur_len;
    logic [CNT_W-1:0]        n_sat;
    logic [NODE_W-1:0]       start_sat;

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_NODE_COUNT) ? {{(32-CNT_W){1'b0}}, r_cfg_n} : 32'd0;
    assign o_stall = (r_state != S_IDLE);
    assign in_xfer = i_valid && !o_stall;
    assign d_we    = in_xfer && (i_opcode == OP_WRITE);
    assign cur_len = r_cyc ? r_len_b : r_len_a;

    assign o_valid    = r_o_valid;
    assign o_cycle_id = r_o_cyc;
    assign o_position = r_o_pos;
    assign o_node     = r_o_node;
    assign o_last     = r_o_last;

    // run parameters from the register and the start field
    always_comb begin
        if (r_cfg_n < CNT_W'(MIN_NODES)) begin
            n_sat = CNT_W'(MIN_NODES);
        end else if (r_cfg_n > CNT_W'(MAX_NODES)) begin
            n_sat = CNT_W'(MAX_NODES);
        end else begin
            n_sat = r_cfg_n;
        end
        if ({1'b0, i_start_node} >= n_sat) begin
            start_sat = NODE_W'(n_sat - CNT_W'(1));
        end else begin
            start_sat = i_start_node;
        end
    end

    // distance store read address
    always_comb begin
        case (r_state)
            S_SC_RD1: d_raddr = {r_q, r_x[NODE_W-1:0]};
            S_P_DFS:  d_raddr = {r_p, r_prev};
            default:  d_raddr = {r_p, r_x[NODE_W-1:0]};
        endcase
    end

    // cycle list port mux
    always_comb begin
        l_we    = 1'b0;
        l_waddr = {r_cyc, r_k};
        l_wdata = r_best_x;
        l_raddr = {r_cyc, r_j};
        case (r_state)
            S_START: begin
                l_we    = 1'b1;
                l_waddr = {1'b0, POS_W'(0)};
                l_wdata = r_start;
            end
            S_FAR_DONE: begin
                l_we    = 1'b1;
                l_waddr = {1'b1, POS_W'(0)};
            end
            S_A1_DONE: begin
                l_we    = 1'b1;
                l_waddr = {1'b0, POS_W'(1)};
            end
            S_B1_DONE: begin
                l_we    = 1'b1;
                l_waddr = {1'b1, POS_W'(1)};
            end
            S_G_INIT: l_raddr = {r_cyc, POS_W'(0)};
            S_I_RD: begin
                l_raddr = {r_cyc, r_k - POS_W'(1)};
                if (r_k == r_gj) begin
                    l_we    = 1'b1;
                    l_waddr = {r_cyc, r_gj};
                    l_wdata = r_gx;
                end
            end
            S_I_WR: begin
                l_we    = 1'b1;
                l_wdata = l_rdata;
            end
            S_O_ISSUE: l_raddr = {r_oc, r_opos};
            default: ;
        endcase
    end

    // shared unit operand select
    always_comb begin
        cmp_req.a    = {1'b0, d_rdata};
        cmp_req.b    = '0;
        cmp_req.c    = '0;
        cmp_req.best = r_best_val;
        cmp_req.have = r_have;
        cmp_req.far  = r_far_mode;
        case (r_state)
            S_SC_RD2: begin
                cmp_req.a = {1'b0, r_d1};
                cmp_req.b = d_rdata;
            end
            S_P_COST: begin
                cmp_req.a    = r_best_val[SUM_W-1:0];
                cmp_req.c    = d_rdata;
                cmp_req.best = r_gcost;
                cmp_req.have = r_ghave;
                cmp_req.far  = 1'b0;
            end
            default: ;
        endcase
    end

    tcgi_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES * MAX_NODES)) u_dist (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr ({i_row_index, i_col_index}),
        .i_wdata (i_distance_value),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    tcgi_ram #(.WIDTH(NODE_W), .DEPTH(2 ** LADDR_W)) u_list (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    tcgi_cmp u_cmp (
        .i_req  (cmp_req),
        .o_val  (cmp_val),
        .o_take (cmp_take)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg_n   <= NODE_COUNT_RST;
            r_o_valid <= 1'b0;
            r_len_a   <= '0;
            r_len_b   <= '0;
            r_used    <= '0;
        end else begin
            if (psel && penable && pwrite && pready && (paddr[2] == REG_NODE_COUNT)) begin
                r_cfg_n <= pwdata[CNT_W-1:0];
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer && (i_opcode == OP_RUN)) begin
                        r_n      <= n_sat;
                        r_full_a <= LEN_W'((n_sat + CNT_W'(1)) >> 1);
                        r_full_b <= LEN_W'(n_sat >> 1);
                        r_start  <= start_sat;
                        r_used   <= MAX_NODES'(1) << start_sat;
                        r_state  <= S_START;
                    end
                end
                S_START: begin
                    r_p        <= r_start;
                    r_pair     <= 1'b0;
                    r_far_mode <= 1'b1;
                    r_x        <= '0;
                    r_have     <= 1'b0;
                    r_ret      <= RET_FAR;
                    r_state    <= S_SC_TEST;
                end
                S_FAR_DONE: begin
                    r_far              <= r_best_x;
                    r_used[r_best_x]   <= 1'b1;
                    r_p                <= r_start;
                    r_far_mode         <= 1'b0;
                    r_x                <= '0;
                    r_have             <= 1'b0;
                    r_ret              <= RET_A1;
                    r_state            <= S_SC_TEST;
                end
                S_A1_DONE: begin
                    r_used[r_best_x] <= 1'b1;
                    r_p              <= r_far;
                    r_x              <= '0;
                    r_have           <= 1'b0;
                    r_ret            <= RET_B1;
                    r_state          <= S_SC_TEST;
                end
                S_B1_DONE: begin
                    r_used[r_best_x] <= 1'b1;
                    r_len_a          <= LEN_W'(2);
                    r_len_b          <= LEN_W'(2);
                    r_cyc            <= 1'b1;
                    r_state          <= S_NEXT;
                end
                // candidate scan over all unused nodes
                S_SC_TEST: begin
                    if (r_x >= r_n) begin
                        case (r_ret)
                            RET_FAR: r_state <= S_FAR_DONE;
                            RET_A1:  r_state <= S_A1_DONE;
                            RET_B1:  r_state <= S_B1_DONE;
                            default: r_state <= S_P_DFS;
                        endcase
                    end else if (r_used[r_x[NODE_W-1:0]]) begin
                        r_x <= r_x + CNT_W'(1);
                    end else begin
                        r_state <= S_SC_RD1;
                    end
                end
                S_SC_RD1: begin
                    if (r_pair) begin
                        r_d1    <= d_rdata;
                        r_state <= S_SC_RD2;
                    end else begin
                        if (cmp_take) begin
                            r_best_x   <= r_x[NODE_W-1:0];
                            r_best_val <= cmp_val;
                            r_have     <= 1'b1;
                        end
                        r_x     <= r_x + CNT_W'(1);
                        r_state <= S_SC_TEST;
                    end
                end
                S_SC_RD2: begin
                    if (cmp_take) begin
                        r_best_x   <= r_x[NODE_W-1:0];
                        r_best_val <= cmp_val;
                        r_have     <= 1'b1;
                    end
                    r_x     <= r_x + CNT_W'(1);
                    r_state <= S_SC_TEST;
                end
                // grow step: walk the pairs of the current cycle
                S_G_INIT: begin
                    r_j     <= POS_W'(1);
                    r_ghave <= 1'b0;
                    r_state <= S_G_RD0;
                end
                S_G_RD0: begin
                    r_prev  <= l_rdata;
                    r_state <= S_P_ISSUE;
                end
                S_P_ISSUE: r_state <= S_P_GET;
                S_P_GET: begin
                    r_p        <= l_rdata;
                    r_q        <= r_prev;
                    r_pair     <= 1'b1;
                    r_far_mode <= 1'b0;
                    r_x        <= '0;
                    r_have     <= 1'b0;
                    r_ret      <= RET_PAIR;
                    r_state    <= S_SC_TEST;
                end
                S_P_DFS: r_state <= S_P_COST;
                S_P_COST: begin
                    if (cmp_take) begin
                        r_gcost <= cmp_val;
                        r_gj    <= r_j;
                        r_gx    <= r_best_x;
                        r_ghave <= 1'b1;
                    end
                    r_prev <= r_p;
                    r_j    <= r_j + POS_W'(1);
                    if (({1'b0, r_j} + LEN_W'(1)) < cur_len) begin
                        r_state <= S_P_ISSUE;
                    end else begin
                        r_k     <= cur_len[POS_W-1:0];
                        r_state <= S_I_RD;
                    end
                end
                // insertion: shift the tail up one entry at a time
                S_I_RD: begin
                    if (r_k == r_gj) begin
                        r_used[r_gx] <= 1'b1;
                        if (r_cyc) begin
                            r_len_b <= r_len_b + LEN_W'(1);
                        end else begin
                            r_len_a <= r_len_a + LEN_W'(1);
                        end
                        r_state <= S_NEXT;
                    end else begin
                        r_state <= S_I_WR;
                    end
                end
                S_I_WR: begin
                    r_k     <= r_k - POS_W'(1);
                    r_state <= S_I_RD;
                end
                // alternate A and B until the sizes are reached
                S_NEXT: begin
                    if (r_cyc) begin
                        if (r_len_a >= r_full_a) begin
                            r_oc    <= 1'b0;
                            r_opos  <= '0;
                            r_state <= S_O_ISSUE;
                        end else begin
                            r_cyc   <= 1'b0;
                            r_state <= S_G_INIT;
                        end
                    end else begin
                        if (r_len_b >= r_full_b) begin
                            r_oc    <= 1'b0;
                            r_opos  <= '0;
                            r_state <= S_O_ISSUE;
                        end else begin
                            r_cyc   <= 1'b1;
                            r_state <= S_G_INIT;
                        end
                    end
                end
                // result transfers
                S_O_ISSUE: r_state <= S_O_LOAD;
                S_O_LOAD: begin
                    r_o_node  <= l_rdata;
                    r_o_cyc   <= r_oc;
                    r_o_pos   <= r_opos;
                    r_o_last  <= r_oc && (({1'b0, r_opos} + LEN_W'(1)) == r_len_b);
                    r_o_valid <= 1'b1;
                    r_state   <= S_O_WAIT;
                end
                S_O_WAIT: begin
                    if (!i_stall) begin
                        r_o_valid <= 1'b0;
                        if (r_o_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            if (!r_oc && (({1'b0, r_opos} + LEN_W'(1)) == r_len_a)) begin
                                r_oc   <= 1'b1;
                                r_opos <= '0;
                            end else begin
                                r_opos <= r_opos + POS_W'(1);
                            end
                            r_state <= S_O_ISSUE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // both cycles together hold every node in use exactly once
    a_len_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_O_ISSUE) |-> ((CNT_W'(r_len_a) + CNT_W'(r_len_b)) == r_n))
        else $error("cycle lengths do not add up to node count");

    a_used_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_O_ISSUE) |-> ($countones(r_used) == int'(r_n)))
        else $error("used flags do not match node count");

    // a pair scan must pick an unused node
    a_pick_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_P_DFS) |-> (r_have && !r_used[r_best_x]))
        else $error("pair scan picked a used node");

    a_last_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_last) |-> r_o_cyc)
        else $error("last transfer not in second cycle");
endmodule
`default_nettype wire
